>>> hdl/bpa_pkg.sv
// Shared constants, codes and controller/datapath types of the bitmap page allocator.
package bpa_pkg;

	// Region capacity in pages; the free map holds one bit per page.
	localparam int MAX_PAGES = 65536;

	// Pages held in one word of the free map, handled together in one cycle.
	localparam int WORD_BITS = 8;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int POP_W     = BIT_W + 1;
	localparam int ROWS      = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int PAGE_W    = ($clog2(MAX_PAGES) > BIT_W) ? $clog2(MAX_PAGES) : BIT_W + 1;
	localparam int ROW_W     = PAGE_W - BIT_W;
	localparam int CNT_W     = PAGE_W + 1;

	// Fixed field widths of the channels.
	localparam int FRAME_W    = 40;
	localparam int NUM_W      = 17;
	localparam int STAT_W     = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = FRAME_W;
	localparam int CMP_W      = (CNT_W > NUM_W) ? CNT_W : NUM_W;

	localparam logic [NUM_W-1:0] TOTAL_RST = NUM_W'(65536);

	// Request functions.
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BASE_FRAME  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PAGES = 1'b1;

	typedef struct packed {
		logic              latch;
		logic              scan_start;
		logic              scan_zero;
		logic              upd_start;
		logic              clr_step;
		logic              load_out;
		logic [STAT_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic n_zero;
		logic is_free;
		logic fits;
		logic try_last;
		logic in_rng;
		logic found;
		logic scan_fail;
		logic upd_done;
		logic clr_last;
		logic reinit;
	} stat_t;

endpackage

>>> hdl/bpa_if.sv
// Channel interfaces of the bitmap page allocator: request, response and configuration.
interface bpa_req_if;
	import bpa_pkg::*;
	logic               valid;
	logic               ready;
	logic               func;
	logic [FRAME_W-1:0] frame;
	logic [NUM_W-1:0]   page_count;
	modport source (output valid, func, frame, page_count, input ready);
	modport sink (input valid, func, frame, page_count, output ready);
endinterface

interface bpa_rsp_if;
	import bpa_pkg::*;
	logic               valid;
	logic               ready;
	logic [STAT_W-1:0]  status;
	logic [FRAME_W-1:0] alloc_frame;
	logic [NUM_W-1:0]   free_pages;
	modport source (output valid, status, alloc_frame, free_pages, input ready);
	modport sink (input valid, status, alloc_frame, free_pages, output ready);
endinterface

interface bpa_cfg_if;
	import bpa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/bpa_ctl.sv
// Controller state machine of the bitmap page allocator.
module bpa_ctl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	input  bpa_pkg::stat_t stat,
	output bpa_pkg::cmd_t  cmd
);
	import bpa_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_EVAL  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_PREP  = 3'd4;
	localparam logic [2:0] S_UPD   = 3'd5;
	localparam logic [2:0] S_RESP  = 3'd6;

	logic [2:0]        state_q, state_d;
	logic              pass_b_q, pass_b_d;
	logic [STAT_W-1:0] code_q, code_d;
	logic              out_valid_q;

	always_comb begin
		state_d  = state_q;
		pass_b_d = pass_b_q;
		code_d   = code_q;
		cmd      = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_EVAL;
				end
			end
			S_EVAL: begin
				if (stat.n_zero) begin
					code_d  = ST_IGNORED;
					state_d = S_RESP;
				end else if (!stat.is_free) begin
					if (!stat.fits) begin
						code_d  = ST_NOFIT;
						state_d = S_RESP;
					end else begin
						// Start next-fit from the last run if it is still inside the region.
						cmd.scan_start = 1'b1;
						cmd.scan_zero  = !stat.try_last;
						pass_b_d       = !stat.try_last;
						state_d        = S_SCAN;
					end
				end else if (!stat.in_rng) begin
					code_d  = ST_IGNORED;
					state_d = S_RESP;
				end else begin
					state_d = S_PREP;
				end
			end
			S_SCAN: begin
				if (stat.found) begin
					state_d = S_PREP;
				end else if (stat.scan_fail) begin
					if (!pass_b_q) begin
						cmd.scan_start = 1'b1;
						cmd.scan_zero  = 1'b1;
						pass_b_d       = 1'b1;
					end else begin
						code_d  = ST_NOFIT;
						state_d = S_RESP;
					end
				end
			end
			S_PREP: begin
				cmd.upd_start = 1'b1;
				state_d       = S_UPD;
			end
			S_UPD: begin
				if (stat.upd_done) begin
					code_d  = ST_DONE;
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!out_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
		// A new region size restarts the clearing pass from any state.
		if (stat.reinit)
			state_d = S_CLEAR;
		cmd.code = code_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			pass_b_q    <= 1'b0;
			code_q      <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			pass_b_q <= pass_b_d;
			code_q   <= code_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

>>> hdl/bpa_dp.sv
// Datapath of the bitmap page allocator: free map, scan and update engine, counters, result register.
module bpa_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bpa_pkg::cmd_t                   cmd,
	output bpa_pkg::stat_t                  stat,
	input  logic                            func,
	input  logic [bpa_pkg::FRAME_W-1:0]     frame,
	input  logic [bpa_pkg::NUM_W-1:0]       page_count,
	input  logic                            cfg_we,
	input  logic [bpa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bpa_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [bpa_pkg::STAT_W-1:0]      status,
	output logic [bpa_pkg::FRAME_W-1:0]     alloc_frame,
	output logic [bpa_pkg::NUM_W-1:0]       free_pages
);
	import bpa_pkg::*;

	// Free map, one bit per page, one row of pages per word.
	logic [WORD_BITS-1:0] map_mem [ROWS];

	logic [FRAME_W-1:0]   base_q;
	logic [NUM_W-1:0]     total_q;
	logic                 func_q;
	logic [FRAME_W-1:0]   frame_q;
	logic [NUM_W-1:0]     n_q;
	logic [PAGE_W-1:0]    first_q;
	logic [PAGE_W-1:0]    last_start_q;
	logic                 last_valid_q;
	logic [CNT_W-1:0]     free_cnt_q;
	logic [ROW_W-1:0]     clr_row_q;

	logic                 act_q, iss_q, mode_q, vld_s1;
	logic [ROW_W-1:0]     rd_row_q, end_row_q, row_s1;
	logic [PAGE_W-1:0]    from_q, lo_q, start_q;
	logic [CNT_W-1:0]     run_q, hi_q;
	logic                 set_q;
	logic [FRAME_W-1:0]   aframe_q;
	logic [WORD_BITS-1:0] rd_data_q;

	logic [STAT_W-1:0]    status_q;
	logic [FRAME_W-1:0]   alloc_frame_q;
	logic [NUM_W-1:0]     free_pages_q;

	logic [CNT_W-1:0]     lim, lim_m1, n_c, rem, hi_pg, hi_m1, run;
	logic [FRAME_W-1:0]   off;
	logic [PAGE_W-1:0]    from_pg, lo_pg, hit_pg;
	logic                 issue, scan_proc, upd_proc, hit;
	logic                 found, scan_fail, upd_done, clr_last, reinit;
	logic [WORD_BITS-1:0] new_w, wr_data;
	logic [POP_W-1:0]     cnt;
	logic                 wr_en;
	logic [ROW_W-1:0]     wr_row;

	// Effective region size is the register value capped at the capacity.
	assign lim    = (CMP_W'(total_q) > CMP_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : CNT_W'(total_q);
	assign lim_m1 = lim - CNT_W'(1);
	assign n_c    = CNT_W'(n_q);
	assign off    = frame_q - base_q;

	assign issue     = act_q && iss_q;
	assign scan_proc = vld_s1 && act_q && !mode_q;
	assign upd_proc  = vld_s1 && act_q && mode_q;
	assign found     = scan_proc && hit;
	assign scan_fail = scan_proc && !hit && (row_s1 == end_row_q);
	assign upd_done  = upd_proc && (row_s1 == end_row_q);
	assign clr_last  = (clr_row_q == ROW_W'(ROWS - 1));
	assign reinit    = cfg_we && (cfg_index == REG_TOTAL_PAGES);
	assign from_pg   = cmd.scan_zero ? '0 : last_start_q;

	assign stat.n_zero    = (n_q == '0);
	assign stat.is_free   = (func_q == FN_FREE);
	assign stat.fits      = (CMP_W'(n_q) <= CMP_W'(lim));
	assign stat.try_last  = last_valid_q && (CNT_W'(last_start_q) < lim);
	assign stat.in_rng    = (frame_q >= base_q) && (off < FRAME_W'(lim));
	assign stat.found     = found;
	assign stat.scan_fail = scan_fail;
	assign stat.upd_done  = upd_done;
	assign stat.clr_last  = clr_last;
	assign stat.reinit    = reinit;

	// Page range of the update pass: a free is clipped at the region end.
	always_comb begin
		rem = lim - CNT_W'(first_q);
		if (func_q == FN_FREE) begin
			lo_pg = first_q;
			if (CMP_W'(rem) < CMP_W'(n_q))
				hi_pg = lim;
			else
				hi_pg = CNT_W'(CMP_W'(first_q) + CMP_W'(n_q));
		end else begin
			lo_pg = start_q;
			hi_pg = CNT_W'(start_q) + n_c;
		end
		hi_m1 = hi_pg - CNT_W'(1);
	end

	// Run search over one row; the run length carries over from the previous row.
	always_comb begin
		logic [PAGE_W-1:0] pg;
		logic              elig;
		run    = run_q;
		hit    = 1'b0;
		hit_pg = '0;
		for (int j = 0; j < WORD_BITS; j++) begin
			pg   = {row_s1, BIT_W'(j)};
			elig = rd_data_q[j] && (pg >= from_q) && (CNT_W'(pg) < lim);
			if (!hit) begin
				run = elig ? run + CNT_W'(1) : '0;
				if (run == n_c) begin
					hit    = 1'b1;
					hit_pg = pg;
				end
			end
		end
	end

	// Row update: pages inside the range take the new value; changed bits are counted.
	always_comb begin
		logic [PAGE_W-1:0]    pg;
		logic [WORD_BITS-1:0] chg;
		for (int j = 0; j < WORD_BITS; j++) begin
			pg       = {row_s1, BIT_W'(j)};
			new_w[j] = ((pg >= lo_q) && (CNT_W'(pg) < hi_q)) ? set_q : rd_data_q[j];
		end
		chg = new_w ^ rd_data_q;
		cnt = '0;
		for (int j = 0; j < WORD_BITS; j++)
			cnt = cnt + POP_W'(chg[j]);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_row  = row_s1;
		wr_data = new_w;
		if (cmd.clr_step) begin
			wr_en   = 1'b1;
			wr_row  = clr_row_q;
			wr_data = '1;
		end else if (upd_proc) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			map_mem[wr_row] <= wr_data;
		if (issue)
			rd_data_q <= map_mem[rd_row_q];
	end

	// Engine control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			iss_q  <= 1'b0;
			mode_q <= 1'b0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.scan_start || cmd.upd_start) begin
				act_q  <= 1'b1;
				iss_q  <= 1'b1;
				mode_q <= cmd.upd_start;
				vld_s1 <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (found || scan_fail || upd_done) begin
					act_q <= 1'b0;
					iss_q <= 1'b0;
				end else if (issue && (rd_row_q == end_row_q)) begin
					iss_q <= 1'b0;
				end
			end
		end
	end

	// Engine payload, request and result registers.
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			rd_row_q  <= from_pg[PAGE_W-1:BIT_W];
			end_row_q <= lim_m1[PAGE_W-1:BIT_W];
			from_q    <= from_pg;
			run_q     <= '0;
		end else if (cmd.upd_start) begin
			rd_row_q  <= lo_pg[PAGE_W-1:BIT_W];
			end_row_q <= hi_m1[PAGE_W-1:BIT_W];
			lo_q      <= lo_pg;
			hi_q      <= hi_pg;
			set_q     <= (func_q == FN_FREE);
		end else begin
			if (issue)
				rd_row_q <= rd_row_q + ROW_W'(1);
			if (scan_proc)
				run_q <= run;
		end
		if (issue)
			row_s1 <= rd_row_q;
		if (found)
			start_q <= PAGE_W'(CNT_W'(hit_pg) + CNT_W'(1) - n_c);
		if (cmd.upd_start && (func_q == FN_ALLOC))
			aframe_q <= base_q + FRAME_W'(start_q);
		if (cmd.latch) begin
			func_q  <= func;
			frame_q <= frame;
			n_q     <= page_count;
		end
		first_q <= off[PAGE_W-1:0];
		if (cmd.load_out) begin
			status_q      <= cmd.code;
			alloc_frame_q <= ((cmd.code == ST_DONE) && (func_q == FN_ALLOC)) ? aframe_q : '0;
			free_pages_q  <= NUM_W'(free_cnt_q);
		end
	end

	// Configuration, allocator state and clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= '0;
			total_q      <= TOTAL_RST;
			last_start_q <= '0;
			last_valid_q <= 1'b0;
			free_cnt_q   <= '0;
			clr_row_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BASE_FRAME:  base_q  <= cfg_data;
					REG_TOTAL_PAGES: total_q <= cfg_data[NUM_W-1:0];
				endcase
			end
			if (reinit) begin
				clr_row_q    <= '0;
				last_valid_q <= 1'b0;
			end else if (cmd.clr_step) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
				if (clr_last)
					free_cnt_q <= lim;
			end
			if (cmd.upd_start && (func_q == FN_ALLOC)) begin
				last_start_q <= start_q;
				last_valid_q <= 1'b1;
			end
			if (upd_proc)
				free_cnt_q <= set_q ? free_cnt_q + CNT_W'(cnt) : free_cnt_q - CNT_W'(cnt);
		end
	end

	assign status      = status_q;
	assign alloc_frame = alloc_frame_q;
	assign free_pages  = free_pages_q;

endmodule

>>> hdl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: next-fit page run allocation over a free-page bitmap.
//
//   channel | role   | payload
//   --------+--------+---------------------------------------------
//   req     | sink   | func, frame, page_count
//   rsp     | source | status, alloc_frame, free_pages
//   cfg     | sink   | index (0 base_frame, 1 total_pages), data
//
// The free map is scanned and updated one row of 8 pages per cycle through one memory port
// each way. From acceptance to the loaded response a free updates the rows its range spans; an
// allocate scans each pass row by row and then updates the rows of its run, a refused one ends
// without an update, and a zero count is answered without a scan.
// After reset and each total_pages write a clearing pass frees every page, and no request is
// taken meanwhile. A stalled response holds in the output register while the next is taken.
module bitmap_page_allocator (
	input logic      clk,
	input logic      arst_n,
	bpa_req_if.sink  req,
	bpa_rsp_if.source rsp,
	bpa_cfg_if.sink  cfg
);
	import bpa_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	bpa_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.func        (req.func),
		.frame       (req.frame),
		.page_count  (req.page_count),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.status      (rsp.status),
		.alloc_frame (rsp.alloc_frame),
		.free_pages  (rsp.free_pages)
	);

`ifndef SYNTHESIS
	// A new region size must start the clearing pass straight away.
	a_reinit_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready && cfg.index == REG_TOTAL_PAGES) |=> !req.ready)
		else $error("request taken right after a total_pages write");

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("second request taken while one is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == ST_DONE || rsp.status == ST_NOFIT ||
			rsp.status == ST_IGNORED))
		else $error("undefined status code on the response");

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_DONE) |-> (rsp.alloc_frame == '0))
		else $error("non-zero frame on a response that is not done");
`endif

endmodule
